// ----- hdl/v3alu_pkg.sv -----
package v3alu_pkg;

    localparam logic [3:0] ACT_ADD    = 4'd0;
    localparam logic [3:0] ACT_SUB    = 4'd1;
    localparam logic [3:0] ACT_MULVEC = 4'd2;
    localparam logic [3:0] ACT_SCALE  = 4'd3;
    localparam logic [3:0] ACT_DIV    = 4'd4;
    localparam logic [3:0] ACT_NEG    = 4'd5;
    localparam logic [3:0] ACT_DOT    = 4'd6;
    localparam logic [3:0] ACT_LENSQ  = 4'd7;
    localparam logic [3:0] ACT_LEN    = 4'd8;
    localparam logic [3:0] ACT_CROSS  = 4'd9;
    localparam logic [3:0] ACT_NORM   = 4'd10;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SAT  = 2'd1;
    localparam logic [1:0] ST_DIVZ = 2'd2;

    localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
    localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

    typedef struct packed {
        logic [3:0]         action;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] az;
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic signed [31:0] bz;
        logic signed [31:0] scalar_in;
    } t_in;

    typedef struct packed {
        logic signed [31:0] rx;
        logic signed [31:0] ry;
        logic signed [31:0] rz;
        logic signed [31:0] scalar_out;
        logic [1:0]         status;
    } t_out;

    typedef struct packed {
        logic signed [31:0] val;
        logic               sat;
    } t_satval;

    function automatic t_satval sat_word(input logic signed [65:0] v);
        t_satval r;
        if (v > SAT_MAX) begin
            r.val = 32'sh7fffffff;
            r.sat = 1'b1;
        end else if (v < SAT_MIN) begin
            r.val = 32'sh80000000;
            r.sat = 1'b1;
        end else begin
            r.val = v[31:0];
            r.sat = 1'b0;
        end
        return r;
    endfunction

endpackage

// ----- hdl/v3alu_lane.sv -----
module v3alu_lane #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic [3:0]         i_act,
    input  logic signed [31:0] i_ai,
    input  logic signed [31:0] i_aj,
    input  logic signed [31:0] i_ak,
    input  logic signed [31:0] i_bi,
    input  logic signed [31:0] i_bj,
    input  logic signed [31:0] i_bk,
    input  logic signed [31:0] i_s,
    output logic signed [63:0] o_pm,
    output logic signed [63:0] o_psq,
    output logic signed [31:0] o_vec,
    output logic               o_vsat
);

    logic [3:0]         r_act;
    logic signed [63:0] r_pm;
    logic signed [63:0] r_psq;
    logic signed [63:0] r_pc0;
    logic signed [63:0] r_pc1;
    logic signed [32:0] r_lin;
    logic signed [32:0] n_lin;
    logic signed [31:0] w_mop;
    logic signed [63:0] w_pm;
    logic signed [63:0] w_psq;
    logic signed [63:0] w_pc0;
    logic signed [63:0] w_pc1;
    logic signed [64:0] w_cd;
    v3alu_pkg::t_satval n_vs;
    logic signed [31:0] r_vec;
    logic               r_vsat;

    assign w_mop = (i_act == v3alu_pkg::ACT_SCALE) ? i_s : i_bi;
    assign w_pm  = i_ai * w_mop;
    assign w_psq = i_ai * i_ai;
    assign w_pc0 = i_aj * i_bk;
    assign w_pc1 = i_ak * i_bj;

    always_comb begin
        case (i_act)
            v3alu_pkg::ACT_ADD: n_lin = 33'(i_ai) + 33'(i_bi);
            v3alu_pkg::ACT_SUB: n_lin = 33'(i_ai) - 33'(i_bi);
            v3alu_pkg::ACT_NEG: n_lin = -33'(i_ai);
            default:            n_lin = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_act <= i_act;
        r_pm  <= w_pm;
        r_psq <= w_psq;
        r_pc0 <= w_pc0;
        r_pc1 <= w_pc1;
        r_lin <= n_lin;
    end

    assign w_cd = 65'(r_pc0) - 65'(r_pc1);

    // The arithmetic right shift of a signed product rounds towards minus infinity.
    always_comb begin
        case (r_act)
            v3alu_pkg::ACT_ADD, v3alu_pkg::ACT_SUB, v3alu_pkg::ACT_NEG:
                n_vs = v3alu_pkg::sat_word(66'(r_lin));
            v3alu_pkg::ACT_MULVEC, v3alu_pkg::ACT_SCALE:
                n_vs = v3alu_pkg::sat_word(66'(r_pm >>> FRAC_BITS));
            v3alu_pkg::ACT_CROSS:
                n_vs = v3alu_pkg::sat_word(66'(w_cd >>> FRAC_BITS));
            default:
                n_vs = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_vec  <= n_vs.val;
        r_vsat <= n_vs.sat;
    end

    assign o_pm   = r_pm;
    assign o_psq  = r_psq;
    assign o_vec  = r_vec;
    assign o_vsat = r_vsat;

endmodule

// ----- hdl/v3alu_sqrt.sv -----
module v3alu_sqrt #(
    parameter int TAG_W = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [63:0]      i_rad,
    input  logic [TAG_W-1:0] i_tag,
    output logic             o_valid,
    output logic [31:0]      o_root,
    output logic [TAG_W-1:0] o_tag
);

    localparam int NS = 32;

    logic             r_vld  [NS];
    logic [34:0]      r_rem  [NS];
    logic [31:0]      r_root [NS];
    logic [63:0]      r_rad  [NS];
    logic [TAG_W-1:0] r_tag  [NS];

    // One root bit per stage, two radicand bits consumed per stage.
    for (genvar g = 0; g < NS; g++) begin : g_stage
        logic             v_in;
        logic [34:0]      rem_in;
        logic [31:0]      root_in;
        logic [63:0]      rad_in;
        logic [TAG_W-1:0] tag_in;
        logic [34:0]      remc;
        logic [34:0]      trial;

        if (g == 0) begin : g_first
            assign v_in    = i_valid;
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = i_rad;
            assign tag_in  = i_tag;
        end else begin : g_next
            assign v_in    = r_vld[g-1];
            assign rem_in  = r_rem[g-1];
            assign root_in = r_root[g-1];
            assign rad_in  = r_rad[g-1];
            assign tag_in  = r_tag[g-1];
        end

        assign remc  = {rem_in[32:0], rad_in[63:62]};
        assign trial = {1'b0, root_in, 2'b01};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else begin
                r_vld[g] <= v_in;
            end
            if (remc >= trial) begin
                r_rem[g]  <= remc - trial;
                r_root[g] <= {root_in[30:0], 1'b1};
            end else begin
                r_rem[g]  <= remc;
                r_root[g] <= {root_in[30:0], 1'b0};
            end
            r_rad[g] <= {rad_in[61:0], 2'b00};
            r_tag[g] <= tag_in;
        end
    end

    assign o_valid = r_vld[NS-1];
    assign o_root  = r_root[NS-1];
    assign o_tag   = r_tag[NS-1];

endmodule

// ----- hdl/v3alu_div.sv -----
module v3alu_div #(
    parameter int NQ    = 48,
    parameter int TAG_W = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [NQ-1:0]    i_num,
    input  logic [31:0]      i_den,
    input  logic             i_neg,
    input  logic [TAG_W-1:0] i_tag,
    output logic             o_valid,
    output logic [NQ-1:0]    o_quot,
    output logic             o_neg,
    output logic [TAG_W-1:0] o_tag
);

    logic             r_vld [NQ];
    logic [31:0]      r_rem [NQ];
    logic [NQ-1:0]    r_num [NQ];
    logic [31:0]      r_den [NQ];
    logic             r_neg [NQ];
    logic [TAG_W-1:0] r_tag [NQ];

    // Restoring division; quotient bits shift in as dividend bits shift out.
    for (genvar g = 0; g < NQ; g++) begin : g_stage
        logic             v_in;
        logic [31:0]      rem_in;
        logic [NQ-1:0]    num_in;
        logic [31:0]      den_in;
        logic             neg_in;
        logic [TAG_W-1:0] tag_in;
        logic [32:0]      remc;
        logic [32:0]      diff;

        if (g == 0) begin : g_first
            assign v_in   = i_valid;
            assign rem_in = '0;
            assign num_in = i_num;
            assign den_in = i_den;
            assign neg_in = i_neg;
            assign tag_in = i_tag;
        end else begin : g_next
            assign v_in   = r_vld[g-1];
            assign rem_in = r_rem[g-1];
            assign num_in = r_num[g-1];
            assign den_in = r_den[g-1];
            assign neg_in = r_neg[g-1];
            assign tag_in = r_tag[g-1];
        end

        assign remc = {rem_in, num_in[NQ-1]};
        assign diff = remc - {1'b0, den_in};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else begin
                r_vld[g] <= v_in;
            end
            if (remc >= {1'b0, den_in}) begin
                r_rem[g] <= diff[31:0];
                r_num[g] <= {num_in[NQ-2:0], 1'b1};
            end else begin
                r_rem[g] <= remc[31:0];
                r_num[g] <= {num_in[NQ-2:0], 1'b0};
            end
            r_den[g] <= den_in;
            r_neg[g] <= neg_in;
            r_tag[g] <= tag_in;
        end
    end

    assign o_valid = r_vld[NQ-1];
    assign o_quot  = r_num[NQ-1];
    assign o_neg   = r_neg[NQ-1];
    assign o_tag   = r_tag[NQ-1];

endmodule

// ----- hdl/vec3_arithmetic_unit.sv -----
// Fully pipelined three-component vector ALU in signed fixed point with FRAC_BITS
// fractional bits. A transaction is taken on every clock edge at which start is
// high and busy is low; busy is high only while reset is applied, so one
// transaction per cycle is sustained. Every operation runs through the same
// pipeline: two stages of products and sums, a 32-stage square root and a
// divider with one stage per quotient bit (32 + FRAC_BITS stages), then an output
// register that drives o_strobe and o_result. The result is present for one cycle
// only: the receiver cannot stall the block and must take it when o_strobe is high.
module vec3_arithmetic_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  v3alu_pkg::t_in    i_data,
    output logic              o_strobe,
    output v3alu_pkg::t_out   o_result
);

    localparam int NQ  = 32 + FRAC_BITS;
    localparam int LAT = 35 + NQ;

    typedef struct packed {
        logic [3:0]       act;
        logic [2:0][31:0] a;
        logic [31:0]      s;
        logic [2:0][31:0] v;
        logic [2:0]       vsat;
        logic [31:0]      sc;
        logic             ssat;
    } t_sq_tag;

    typedef struct packed {
        logic [31:0] v;
        logic        vsat;
    } t_dv_lane;

    typedef struct packed {
        logic [3:0]  act;
        logic [31:0] sc;
        logic        ssat;
        logic        zero;
        t_dv_lane    ln;
    } t_dv_com;

    logic                     w_acc;
    logic signed [31:0]       w_a [3];
    logic signed [31:0]       w_b [3];
    logic signed [63:0]       w_pm [3];
    logic signed [63:0]       w_psq [3];
    logic signed [31:0]       w_vec [3];
    logic                     w_vsat [3];
    logic signed [63:0]       w_sel [3];
    logic signed [65:0]       w_fl [3];

    logic                     r_v1;
    logic [3:0]               r_act1;
    logic [2:0][31:0]         r_a1;
    logic [31:0]              r_s1;
    logic                     r_v2;
    logic [3:0]               r_act2;
    logic [2:0][31:0]         r_a2;
    logic [31:0]              r_s2;
    logic signed [65:0]       r_sum2;
    logic signed [65:0]       n_sum2;
    logic [63:0]              r_sumsq2;
    logic [63:0]              n_sumsq2;

    v3alu_pkg::t_satval       w_ssv;
    t_sq_tag                  w_sq_in;
    t_sq_tag                  w_sq_out;
    logic                     w_sq_valid;
    logic [31:0]              w_root;
    logic                     w_act_div;
    logic [31:0]              w_smag;
    logic [31:0]              w_den;
    logic [31:0]              w_amag [3];
    logic                     w_neg_in [3];
    t_dv_com                  w_dc_in;
    t_dv_com                  w_dc_out;
    t_dv_lane                 w_dl_out [1:2];

    logic                     w_dv_valid [3];
    logic [NQ-1:0]            w_quot [3];
    logic                     w_qneg [3];
    v3alu_pkg::t_satval       w_qs [3];
    t_dv_lane                 w_lt [3];
    logic                     w_anysat;
    v3alu_pkg::t_out          n_out;
    v3alu_pkg::t_out          r_out;
    logic                     r_strobe;

    assign busy  = ~i_rst_n;
    assign w_acc = start & ~busy;

    assign w_a[0] = i_data.ax;
    assign w_a[1] = i_data.ay;
    assign w_a[2] = i_data.az;
    assign w_b[0] = i_data.bx;
    assign w_b[1] = i_data.by;
    assign w_b[2] = i_data.bz;

    for (genvar g = 0; g < 3; g++) begin : g_lane
        v3alu_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .i_clk  (i_clk),
            .i_act  (i_data.action),
            .i_ai   (w_a[g]),
            .i_aj   (w_a[(g + 1) % 3]),
            .i_ak   (w_a[(g + 2) % 3]),
            .i_bi   (w_b[g]),
            .i_bj   (w_b[(g + 1) % 3]),
            .i_bk   (w_b[(g + 2) % 3]),
            .i_s    (i_data.scalar_in),
            .o_pm   (w_pm[g]),
            .o_psq  (w_psq[g]),
            .o_vec  (w_vec[g]),
            .o_vsat (w_vsat[g])
        );

        assign w_sel[g] = (r_act1 == v3alu_pkg::ACT_LENSQ) ? w_psq[g] : w_pm[g];
        assign w_fl[g]  = 66'(w_sel[g] >>> FRAC_BITS);
    end

    assign n_sum2   = w_fl[0] + w_fl[1] + w_fl[2];
    assign n_sumsq2 = w_psq[0] + w_psq[1] + w_psq[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= w_acc;
            r_v2 <= r_v1;
        end
        r_act1   <= i_data.action;
        r_a1     <= {i_data.az, i_data.ay, i_data.ax};
        r_s1     <= i_data.scalar_in;
        r_act2   <= r_act1;
        r_a2     <= r_a1;
        r_s2     <= r_s1;
        r_sum2   <= n_sum2;
        r_sumsq2 <= n_sumsq2;
    end

    assign w_ssv = v3alu_pkg::sat_word(r_sum2);

    always_comb begin
        w_sq_in.act  = r_act2;
        w_sq_in.a    = r_a2;
        w_sq_in.s    = r_s2;
        w_sq_in.v    = {w_vec[2], w_vec[1], w_vec[0]};
        w_sq_in.vsat = {w_vsat[2], w_vsat[1], w_vsat[0]};
        if (r_act2 == v3alu_pkg::ACT_DOT || r_act2 == v3alu_pkg::ACT_LENSQ) begin
            w_sq_in.sc   = w_ssv.val;
            w_sq_in.ssat = w_ssv.sat;
        end else begin
            w_sq_in.sc   = '0;
            w_sq_in.ssat = 1'b0;
        end
    end

    v3alu_sqrt #(
        .TAG_W ($bits(t_sq_tag))
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v2),
        .i_rad   (r_sumsq2),
        .i_tag   (w_sq_in),
        .o_valid (w_sq_valid),
        .o_root  (w_root),
        .o_tag   (w_sq_out)
    );

    assign w_act_div = (w_sq_out.act == v3alu_pkg::ACT_DIV);
    assign w_smag    = w_sq_out.s[31] ? (32'd0 - w_sq_out.s) : w_sq_out.s;
    assign w_den     = w_act_div ? w_smag : w_root;

    always_comb begin
        w_dc_in.act  = w_sq_out.act;
        w_dc_in.sc   = w_sq_out.sc;
        w_dc_in.ssat = w_sq_out.ssat;
        if (w_sq_out.act == v3alu_pkg::ACT_LEN) begin
            w_dc_in.sc   = w_root[31] ? 32'h7fffffff : w_root;
            w_dc_in.ssat = w_root[31];
        end
        w_dc_in.zero = (w_act_div && w_sq_out.s == 32'd0) ||
                       (w_sq_out.act == v3alu_pkg::ACT_NORM && w_root == 32'd0);
        w_dc_in.ln.v    = w_sq_out.v[0];
        w_dc_in.ln.vsat = w_sq_out.vsat[0];
    end

    for (genvar g = 0; g < 3; g++) begin : g_div
        assign w_amag[g]   = w_sq_out.a[g][31] ? (32'd0 - w_sq_out.a[g]) : w_sq_out.a[g];
        assign w_neg_in[g] = w_sq_out.a[g][31] ^ (w_act_div & w_sq_out.s[31]);

        if (g == 0) begin : g_com
            v3alu_div #(
                .NQ    (NQ),
                .TAG_W ($bits(t_dv_com))
            ) u_div (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_valid (w_sq_valid),
                .i_num   ({w_amag[g], {FRAC_BITS{1'b0}}}),
                .i_den   (w_den),
                .i_neg   (w_neg_in[g]),
                .i_tag   (w_dc_in),
                .o_valid (w_dv_valid[g]),
                .o_quot  (w_quot[g]),
                .o_neg   (w_qneg[g]),
                .o_tag   (w_dc_out)
            );
            assign w_lt[g] = w_dc_out.ln;
        end else begin : g_plain
            t_dv_lane w_tin;

            assign w_tin.v    = w_sq_out.v[g];
            assign w_tin.vsat = w_sq_out.vsat[g];

            v3alu_div #(
                .NQ    (NQ),
                .TAG_W ($bits(t_dv_lane))
            ) u_div (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_valid (w_sq_valid),
                .i_num   ({w_amag[g], {FRAC_BITS{1'b0}}}),
                .i_den   (w_den),
                .i_neg   (w_neg_in[g]),
                .i_tag   (w_tin),
                .o_valid (w_dv_valid[g]),
                .o_quot  (w_quot[g]),
                .o_neg   (w_qneg[g]),
                .o_tag   (w_dl_out[g])
            );
            assign w_lt[g] = w_dl_out[g];
        end

        assign w_qs[g] = v3alu_pkg::sat_word(w_qneg[g] ? (66'd0 - 66'(w_quot[g]))
                                                       : 66'(w_quot[g]));
    end

    // Merge the lanes and pick the fields that the operation returns.
    always_comb begin
        n_out    = '0;
        w_anysat = 1'b0;
        case (w_dc_out.act)
            v3alu_pkg::ACT_ADD, v3alu_pkg::ACT_SUB, v3alu_pkg::ACT_MULVEC,
            v3alu_pkg::ACT_SCALE, v3alu_pkg::ACT_NEG, v3alu_pkg::ACT_CROSS: begin
                n_out.rx = w_lt[0].v;
                n_out.ry = w_lt[1].v;
                n_out.rz = w_lt[2].v;
                w_anysat = w_lt[0].vsat | w_lt[1].vsat | w_lt[2].vsat;
            end
            v3alu_pkg::ACT_DIV, v3alu_pkg::ACT_NORM: begin
                if (!w_dc_out.zero) begin
                    n_out.rx = w_qs[0].val;
                    n_out.ry = w_qs[1].val;
                    n_out.rz = w_qs[2].val;
                    w_anysat = w_qs[0].sat | w_qs[1].sat | w_qs[2].sat;
                end
            end
            v3alu_pkg::ACT_DOT, v3alu_pkg::ACT_LENSQ, v3alu_pkg::ACT_LEN: begin
                n_out.scalar_out = w_dc_out.sc;
                w_anysat         = w_dc_out.ssat;
            end
            default: begin
            end
        endcase
        if (w_dc_out.act == v3alu_pkg::ACT_DIV && w_dc_out.zero) begin
            n_out.status = v3alu_pkg::ST_DIVZ;
        end else if (w_anysat) begin
            n_out.status = v3alu_pkg::ST_SAT;
        end else begin
            n_out.status = v3alu_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_dv_valid[0];
        end
        r_out <= n_out;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

    a_lanes_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_dv_valid[0] == w_dv_valid[1]) && (w_dv_valid[0] == w_dv_valid[2]))
        else $error("divider lanes out of step");

    a_fixed_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(w_acc, LAT))
        else $error("result strobe without a matching transaction");

    a_divz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.status == v3alu_pkg::ST_DIVZ) |->
        (o_result.rx == 32'sd0 && o_result.ry == 32'sd0 &&
         o_result.rz == 32'sd0 && o_result.scalar_out == 32'sd0))
        else $error("divide by zero result is not all zero");

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int Q = 16;
    localparam int LATENCY = 67 + Q;
    localparam longint CYCLE_LIMIT = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    v3alu_pkg::t_in i_data = '0;
    logic o_strobe;
    v3alu_pkg::t_out o_result;

    v3alu_pkg::t_out expected_q[$];
    int errors = 0;
    longint cycle_count = 0;
    int burst_left = 0;

    always #2 i_clk = ~i_clk;

    vec3_arithmetic_unit #(.FRAC_BITS(Q)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_data(i_data), .o_strobe(o_strobe), .o_result(o_result)
    );

    function automatic logic signed [127:0] floor_q(input logic signed [127:0] v);
        return v >>> Q;
    endfunction

    function automatic logic signed [31:0] clamp(input logic signed [127:0] v,
                                                 inout logic flag);
        if (v > 128'sd2147483647) begin
            flag = 1'b1;
            return 32'sh7fffffff;
        end
        if (v < -128'sd2147483648) begin
            flag = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic [63:0] root_floor(input logic [63:0] v);
        logic [63:0] rem, root, b;
        rem = v;
        root = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (rem >= root + b) begin
                rem = rem - (root + b);
                root = (root >> 1) + b;
            end else begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return root;
    endfunction

    // Signed division truncating toward zero, done on magnitudes to be explicit.
    function automatic logic signed [127:0] div_trunc(input logic signed [127:0] n,
                                                      input logic signed [127:0] d);
        logic [127:0] un, ud, uq;
        un = n < 0 ? -n : n;
        ud = d < 0 ? -d : d;
        uq = un / ud;
        return ((n < 0) != (d < 0)) ? -$signed(uq) : $signed(uq);
    endfunction

    function automatic v3alu_pkg::t_out vector_result(input v3alu_pkg::t_in it);
        v3alu_pkg::t_out r;
        logic flag;
        logic signed [127:0] a[3], b[3], s, v[3], acc;
        logic [63:0] sumsq, len;
        r = '0;
        flag = 1'b0;
        a[0] = it.ax; a[1] = it.ay; a[2] = it.az;
        b[0] = it.bx; b[1] = it.by; b[2] = it.bz;
        s = it.scalar_in;
        sumsq = 0;
        for (int i = 0; i < 3; i++) sumsq = sumsq + 64'(a[i] * a[i]);
        for (int i = 0; i < 3; i++) v[i] = 0;
        acc = 0;
        case (it.action)
            v3alu_pkg::ACT_ADD:    for (int i = 0; i < 3; i++) v[i] = a[i] + b[i];
            v3alu_pkg::ACT_SUB:    for (int i = 0; i < 3; i++) v[i] = a[i] - b[i];
            v3alu_pkg::ACT_MULVEC:
                for (int i = 0; i < 3; i++) v[i] = floor_q(a[i] * b[i]);
            v3alu_pkg::ACT_SCALE:  for (int i = 0; i < 3; i++) v[i] = floor_q(a[i] * s);
            v3alu_pkg::ACT_DIV:
                if (s != 0)
                    for (int i = 0; i < 3; i++) v[i] = div_trunc(a[i] <<< Q, s);
            v3alu_pkg::ACT_NEG:    for (int i = 0; i < 3; i++) v[i] = -a[i];
            v3alu_pkg::ACT_DOT:
                for (int i = 0; i < 3; i++) acc = acc + floor_q(a[i] * b[i]);
            v3alu_pkg::ACT_LENSQ:
                for (int i = 0; i < 3; i++) acc = acc + floor_q(a[i] * a[i]);
            v3alu_pkg::ACT_LEN:    acc = $signed({64'd0, root_floor(sumsq)});
            v3alu_pkg::ACT_CROSS: begin
                v[0] = floor_q(a[1] * b[2] - a[2] * b[1]);
                v[1] = floor_q(a[2] * b[0] - a[0] * b[2]);
                v[2] = floor_q(a[0] * b[1] - a[1] * b[0]);
            end
            v3alu_pkg::ACT_NORM: begin
                len = root_floor(sumsq);
                if (len != 0)
                    for (int i = 0; i < 3; i++)
                        v[i] = div_trunc(a[i] <<< Q, $signed({64'd0, len}));
            end
            default: ;
        endcase
        r.rx = clamp(v[0], flag);
        r.ry = clamp(v[1], flag);
        r.rz = clamp(v[2], flag);
        r.scalar_out = clamp(acc, flag);
        if (it.action == v3alu_pkg::ACT_DIV && s == 0) r.status = v3alu_pkg::ST_DIVZ;
        else if (flag) r.status = v3alu_pkg::ST_SAT;
        else r.status = v3alu_pkg::ST_OK;
        return r;
    endfunction

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Results cannot be held off, so every strobe is a transaction.
    always @(posedge i_clk) begin
        v3alu_pkg::t_out exp_r;
        if (i_rst_n && o_strobe) begin
            if (expected_q.size() == 0) begin
                $error("result with nothing expected: %p", o_result);
                errors++;
            end else begin
                exp_r = expected_q.pop_front();
                if (o_result.rx !== exp_r.rx) begin
                    $error("rx expected %h actual %h", exp_r.rx, o_result.rx); errors++;
                end
                if (o_result.ry !== exp_r.ry) begin
                    $error("ry expected %h actual %h", exp_r.ry, o_result.ry); errors++;
                end
                if (o_result.rz !== exp_r.rz) begin
                    $error("rz expected %h actual %h", exp_r.rz, o_result.rz); errors++;
                end
                if (o_result.scalar_out !== exp_r.scalar_out) begin
                    $error("scalar_out expected %h actual %h",
                           exp_r.scalar_out, o_result.scalar_out);
                    errors++;
                end
                if (o_result.status !== exp_r.status) begin
                    $error("status expected %0d actual %0d", exp_r.status, o_result.status);
                    errors++;
                end
            end
        end
    end

    // Start stays high through a burst and drops only for a gap.
    task automatic send_op(input v3alu_pkg::t_in it);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        start <= 1'b1;
        i_data <= it;
        do @(posedge i_clk); while (busy);
        expected_q.push_back(vector_result(it));
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h0;
            3: return $urandom_range(0, 1) ? 32'h00010000 : 32'hffff0000;
            4: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
            default: return $urandom;
        endcase
    endfunction

    function automatic v3alu_pkg::t_in random_op();
        v3alu_pkg::t_in it;
        it.action = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(11, 15))
                                                 : 4'($urandom_range(0, 10));
        it.ax = rand_word(); it.ay = rand_word(); it.az = rand_word();
        it.bx = rand_word(); it.by = rand_word(); it.bz = rand_word();
        it.scalar_in = rand_word();
        return it;
    endfunction

    task automatic drain();
        start <= 1'b0;
        burst_left = 0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic test_directed();
        v3alu_pkg::t_in it;
        logic [3:0] ops[11] = '{v3alu_pkg::ACT_ADD, v3alu_pkg::ACT_SUB,
                                v3alu_pkg::ACT_MULVEC, v3alu_pkg::ACT_SCALE,
                                v3alu_pkg::ACT_DIV, v3alu_pkg::ACT_NEG,
                                v3alu_pkg::ACT_DOT, v3alu_pkg::ACT_LENSQ,
                                v3alu_pkg::ACT_LEN, v3alu_pkg::ACT_CROSS,
                                v3alu_pkg::ACT_NORM};
        // Every operation on full-scale vector operands and a scalar of one half, so each saturates where it can.
        foreach (ops[k]) begin
            it = '{ops[k], 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                   32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh00008000};
            send_op(it);
        end
        it = '{v3alu_pkg::ACT_DIV, 32'sh00010000, -32'sh00020000, 32'sh0, 0, 0, 0, 32'sh0};
        send_op(it);
        it = '{v3alu_pkg::ACT_NORM, 0, 0, 0, 32'sh1234, 0, 0, 0};
        send_op(it);
        it = '{v3alu_pkg::ACT_NORM, 32'sh00030000, 32'sh00040000, 0, 0, 0, 0, 0};
        send_op(it);
        it = '{v3alu_pkg::ACT_NEG, 32'sh80000000, 0, -32'sh1, 0, 0, 0, 0};
        send_op(it);
        it = '{v3alu_pkg::ACT_DIV, 32'sh7fffffff, 32'sh80000000, 1, 0, 0, 0, 32'sh1};
        send_op(it);
        it = '{v3alu_pkg::ACT_LEN, 32'sh80000000, 32'sh80000000, 32'sh80000000,
               0, 0, 0, 0};
        send_op(it);
        it = '{4'd11, 1, 2, 3, 4, 5, 6, 7};
        send_op(it);
        it = '{4'd15, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
               32'hffffffff, 32'hffffffff, 32'hffffffff};
        send_op(it);
        it = '{v3alu_pkg::ACT_SCALE, -32'sh1, 32'sh1, -32'sh3, 0, 0, 0, 32'sh00008000};
        send_op(it);
    endtask

    task automatic test_random(input int count);
        repeat (count) send_op(random_op());
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        drain();
        test_random(650);
        // Hold off until the pipeline is empty, then resume with random bursts and gaps.
        drain();
        test_random(650);
        drain();
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
